@@ rtl/core/top_k_nearest_select_assert.svh @@
// Assertion macros shared by the checker of the top-k nearest selection block.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef TOP_K_NEAREST_SELECT_ASSERT_SVH
`define TOP_K_NEAREST_SELECT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TKNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tkns_pkg.sv @@
// Package for the top-k nearest selection block: field widths, word types and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package tkns_pkg;

  localparam int ID_W       = 31;
  localparam int DIST_W     = 32;
  localparam int KEEP_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_ID    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 5'd16;
  localparam logic [ID_W-1:0]   SEED_ID_RST    = '0;

  // Input word: one candidate.
  typedef struct packed {
    logic [ID_W-1:0]   candidate_id;
    logic [DIST_W-1:0] distance;
    logic              last_candidate;
  } cand_t;

  // Output word: one kept neighbor or the empty marker.
  typedef struct packed {
    logic [ID_W-1:0]   neighbor_id;
    logic [DIST_W-1:0] neighbor_distance;
    logic              entry_valid;
    logic              last_result;
  } nbr_t;

endpackage

@@ rtl/core/top_k_nearest_select.sv @@
// Top-k nearest selection. Candidates (id, distance) enter at one word per clock
// while no last candidate is held, and are inserted into a sorted list of
// LIST_DEPTH registers by a parallel compare-and-shift, so a candidate is taken
// every cycle; the combinational compare over all list entries is what sets
// that rate. Words pass through an input register, which feeds the list.
// On the candidate marked last, the updated list is copied into a drain buffer
// and the live list restarts empty; the buffer then sends one neighbor per
// cycle through the output register while it is not stalled, ascending by
// distance, with ties in arrival order, the final word marked. A run that
// kept nothing sends one empty marker word. A last candidate waits in the input
// register while the previous run is still draining; other candidates keep
// flowing in during the drain.
// Depends on tkns_pkg.
`timescale 1ns / 1ps

module top_k_nearest_select #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkns_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tkns_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tkns_pkg::cand_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tkns_pkg::nbr_t                out_data_o
);

  import tkns_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // Configuration registers.
  logic [KEEP_W-1:0] keep_count_q;
  logic [ID_W-1:0]   seed_id_q;

  // Input register.
  logic  in_vld_q;
  cand_t in_q;

  // Live sorted list.
  logic [ID_W-1:0]   id_q   [LIST_DEPTH];
  logic [DIST_W-1:0] dist_q [LIST_DEPTH];
  logic [CNT_W-1:0]  cnt_q;

  // Drain buffer for a finished run.
  logic [ID_W-1:0]   snap_id_q   [LIST_DEPTH];
  logic [DIST_W-1:0] snap_dist_q [LIST_DEPTH];
  logic [CNT_W-1:0]  snap_n_q;
  logic              snap_vld_q;

  // Output register.
  logic out_vld_q;
  nbr_t out_q;

  // Insertion logic signals.
  logic [ID_W-1:0]       nxt_id   [LIST_DEPTH];
  logic [DIST_W-1:0]     nxt_dist [LIST_DEPTH];
  logic [ID_W-1:0]       sh_id    [LIST_DEPTH];
  logic [DIST_W-1:0]     sh_dist  [LIST_DEPTH];
  logic [CNT_W-1:0]      nxt_cnt;
  logic [LIST_DEPTH-1:0] ent_vld;
  logic [LIST_DEPTH-1:0] lt;
  logic [LIST_DEPTH:0]   lt_sh;
  logic [CMP_W-1:0]      keep_lim;
  logic                  room;
  logic                  gt_any;
  logic                  ins;

  // Handshake signals.
  logic out_load;
  logic pop;
  logic pop_last;
  logic snap_free;
  logic proc_go;
  logic snap_load;
  nbr_t pop_word;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_COUNT_RST;
      seed_id_q    <= SEED_ID_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEEP_COUNT: keep_count_q <= cfg_data_i[KEEP_W-1:0];
        REG_SEED_ID:    seed_id_q    <= cfg_data_i[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Drain side: the head of the buffer goes out whenever the output register frees.
  assign out_load  = !out_vld_q || out_ready_i;
  assign pop       = snap_vld_q && out_load;
  assign pop_last  = (snap_n_q == '0) || (snap_n_q == ONE_C);
  assign snap_free = !snap_vld_q || (pop && pop_last);

  // A last candidate needs a free drain buffer; others always proceed.
  assign proc_go    = in_vld_q && (!in_q.last_candidate || snap_free);
  assign snap_load  = proc_go && in_q.last_candidate;
  assign in_ready_o = !in_vld_q || proc_go;

  // Compare the candidate against every kept entry at once.
  always_comb begin
    keep_lim = (CMP_W'(keep_count_q) > DEPTH_C) ? DEPTH_C : CMP_W'(keep_count_q);
    room     = CMP_W'(cnt_q) < keep_lim;
    gt_any   = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ent_vld[i] = CNT_W'(i) < cnt_q;
      lt[i]      = ent_vld[i] && (dist_q[i] <= in_q.distance);
      gt_any     = gt_any | (ent_vld[i] && (dist_q[i] > in_q.distance));
    end
    lt_sh = {lt, 1'b1};
    // When full, a strictly smaller distance pushes out the tail entry.
    ins     = (in_q.candidate_id != seed_id_q) && (room || gt_any);
    nxt_cnt = (ins && room) ? cnt_q + ONE_C : cnt_q;
  end

  // Shift network: entries at or after the insert point move down by one.
  always_comb begin
    sh_id[0]   = in_q.candidate_id;
    sh_dist[0] = in_q.distance;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      sh_id[i]   = id_q[i-1];
      sh_dist[i] = dist_q[i-1];
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      nxt_id[i]   = id_q[i];
      nxt_dist[i] = dist_q[i];
      if (ins && !lt[i]) begin
        if (lt_sh[i]) begin
          nxt_id[i]   = in_q.candidate_id;
          nxt_dist[i] = in_q.distance;
        end else begin
          nxt_id[i]   = sh_id[i];
          nxt_dist[i] = sh_dist[i];
        end
      end
    end
  end

  // Word presented by the drain buffer; an empty run gives the marker.
  always_comb begin
    pop_word.entry_valid       = snap_n_q != '0;
    pop_word.neighbor_id       = pop_word.entry_valid ? snap_id_q[0] : '0;
    pop_word.neighbor_distance = pop_word.entry_valid ? snap_dist_q[0] : '0;
    pop_word.last_result       = pop_last;
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (proc_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Live list count; a last candidate hands the list over and restarts it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (proc_go) begin
      cnt_q <= in_q.last_candidate ? '0 : nxt_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      id_q   <= nxt_id;
      dist_q <= nxt_dist;
    end
  end

  // Drain buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      snap_n_q   <= '0;
    end else if (snap_load) begin
      snap_vld_q <= 1'b1;
      snap_n_q   <= nxt_cnt;
    end else if (pop) begin
      snap_vld_q <= !pop_last;
      snap_n_q   <= pop_last ? '0 : snap_n_q - ONE_C;
    end
  end

  // Drain buffer contents: loaded whole, then shifted toward the head.
  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_id_q   <= nxt_id;
      snap_dist_q <= nxt_dist;
    end else if (pop) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        snap_id_q[i]   <= snap_id_q[i+1];
        snap_dist_q[i] <= snap_dist_q[i+1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= pop_word;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/tkns_checker.sv @@
// Port-level checker for the top-k nearest selection block, bound to the top level.
// Depends on tkns_pkg and the macros in top_k_nearest_select_assert.svh.
`timescale 1ns / 1ps

`include "top_k_nearest_select_assert.svh"

module tkns_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input tkns_pkg::cand_t                 in_data_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input tkns_pkg::nbr_t                  out_data_o
);

  import tkns_pkg::*;

  logic              in_acc;
  logic              out_acc;
  logic [2:0]        pend_q;
  logic              in_run_q;
  logic [DIST_W-1:0] prev_dist_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Runs opened by a last candidate and not yet closed by a last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc && in_data_i.last_candidate)
                       - 3'(out_acc && out_data_o.last_result);
    end
  end

  // Track the previous distance sent within the current run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q <= 1'b0;
    end else if (out_acc) begin
      in_run_q <= !out_data_o.last_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      prev_dist_q <= out_data_o.neighbor_distance;
    end
  end

  // A stalled result word holds.
  `TKNS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // The empty marker always closes its run.
  `TKNS_ASSERT_NOW(a_marker_last, out_valid_o && !out_data_o.entry_valid, out_data_o.last_result, "empty marker not marked last")

  // Words within a run are real entries in ascending distance order.
  `TKNS_ASSERT_NOW(a_ascending, out_acc && in_run_q, out_data_o.entry_valid && (out_data_o.neighbor_distance >= prev_dist_q), "run not in ascending distance order")

  // No result appears without a last candidate that asked for it.
  `TKNS_ASSERT_NOW(a_no_spurious, out_valid_o, pend_q != 3'd0, "result word without a pending run")

endmodule

bind top_k_nearest_select tkns_checker u_tkns_checker (.*);
